// ----- hdl/gtbr_pkg.sv -----
// Package for the generation-tagged block ring reader: field widths, codes,
// the command, slot and result records, and the back-end state type.
// No dependencies.
package gtbr_pkg;

	// Default ring depth; the top level overrides it through its parameter.
	localparam int RING_BLOCKS      = 8;
	localparam int MAX_BLOCK_FRAMES = 4096;

	// Fixed field widths of the ports
	localparam int FRAME_BITS = 48;
	localparam int GEN_BITS   = 16;
	localparam int LEN_W      = 13;
	localparam int OFS_W      = 12;
	localparam int SLOT_W     = 3;
	localparam int SEEK_W     = 47;
	localparam int FILL_OUT_W = 4;
	localparam int TOTAL_W    = 32;

	// Frame distance is clamped to +-DIFF_CAP, which keeps the slot math narrow
	localparam int DIFF_CAP = 1 << 20;
	localparam int DIFF_W   = 22;
	localparam int CALC_W   = 24;

	// Depth of the command queue and of the result queue
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		CMD_PUSH   = 1'b0,
		CMD_RENDER = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_COPY   = 2'd0,
		KIND_RENDER = 2'd1,
		KIND_PUSH   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNDERRUN = 2'd1,
		ST_FULL     = 2'd2,
		ST_STALE    = 2'd3
	} status_t;

	// Classified command as it leaves the front end
	typedef struct packed {
		cmd_t                  command;
		logic [FRAME_BITS-1:0] frame;
		logic [LEN_W-1:0]      frames;
		logic [GEN_BITS-1:0]   gen;
	} cmd_item_t;

	// One ring slot descriptor
	typedef struct packed {
		logic [FRAME_BITS-1:0] first;
		logic [LEN_W-1:0]      length;
		logic [LEN_W-1:0]      used;
		logic [GEN_BITS-1:0]   tag;
	} slot_t;

	// One result item
	typedef struct packed {
		kind_t                kind;
		logic [SLOT_W-1:0]    slot_index;
		logic [OFS_W-1:0]     source_offset;
		logic [OFS_W-1:0]     dest_offset;
		logic [LEN_W-1:0]     copy_frames;
		status_t              status;
		logic                 seek_request;
		logic [SEEK_W-1:0]    seek_frame;
		logic [FILL_OUT_W-1:0] ring_fill;
		logic [TOTAL_W-1:0]   stale_dropped_total;
		logic [TOTAL_W-1:0]   underrun_total;
		logic                 last;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PUSH,
		BK_ISSUE,
		BK_EVAL,
		BK_DECIDE,
		BK_STATUS
	} back_state_t;

endpackage

// ----- hdl/gtbr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/gtbr_fifo.sv -----
// Small register FIFO with full/empty flags, used for the command and result queues.
// No dependencies.
module gtbr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// Store an entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and the occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/gtbr_front.sv -----
// Front end: accepts input items, clamps the frame count and queues classified commands.
// Depends on gtbr_pkg and gtbr_fifo.
module gtbr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          command,
	input  logic [gtbr_pkg::FRAME_BITS-1:0] start_frame,
	input  logic [gtbr_pkg::LEN_W-1:0]    frame_count,
	input  logic [gtbr_pkg::GEN_BITS-1:0] generation,
	output logic                          cmd_valid,
	output gtbr_pkg::cmd_item_t           cmd_item,
	input  logic                          cmd_pop
);

	localparam int ITEM_W = $bits(gtbr_pkg::cmd_item_t);
	localparam logic [gtbr_pkg::LEN_W-1:0] MAX_N = gtbr_pkg::LEN_W'(gtbr_pkg::MAX_BLOCK_FRAMES);

	gtbr_pkg::cmd_item_t in_item;
	logic [ITEM_W-1:0]   head;
	logic                q_empty;

	// Classify the item and saturate oversized lengths
	always_comb begin
		in_item.command = gtbr_pkg::cmd_t'(command);
		in_item.frame   = start_frame;
		in_item.frames  = (frame_count > MAX_N) ? MAX_N : frame_count;
		in_item.gen     = generation;
	end

	gtbr_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(gtbr_pkg::QUEUE_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (in_item),
		.full  (full),
		.rd    (cmd_pop),
		.rdata (head),
		.empty (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd_item  = gtbr_pkg::cmd_item_t'(head);

endmodule

// ----- hdl/gtbr_back.sv -----
// Back end: executes pushes and renders against the slot ring and builds result items.
// Depends on gtbr_pkg and gtbr_ram.
module gtbr_back #(
	parameter int RING_BLOCKS = gtbr_pkg::RING_BLOCKS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  gtbr_pkg::cmd_item_t cmd_item,
	output logic                cmd_pop,
	input  logic                res_full,
	output logic                res_push,
	output gtbr_pkg::result_t   res_item
);

	localparam int PTR_W  = $clog2(RING_BLOCKS);
	localparam int FILL_W = $clog2(RING_BLOCKS + 1);
	localparam int SLOT_BITS = $bits(gtbr_pkg::slot_t);
	localparam int FW     = gtbr_pkg::FRAME_BITS;
	localparam int LW     = gtbr_pkg::LEN_W;
	localparam int CW     = gtbr_pkg::CALC_W;
	localparam int DW     = gtbr_pkg::DIFF_W;
	localparam int TW     = gtbr_pkg::TOTAL_W;
	localparam logic signed [FW:0] CAP_HI = (FW+1)'(gtbr_pkg::DIFF_CAP);
	localparam logic signed [FW:0] CAP_LO = -CAP_HI;
	localparam logic [FILL_W-1:0]  RING_N = FILL_W'(RING_BLOCKS);

	gtbr_pkg::back_state_t state_q, state_d;

	gtbr_pkg::cmd_item_t   item_q;
	logic [PTR_W-1:0]      rp_q;
	logic [PTR_W-1:0]      wp_q;
	logic [FILL_W-1:0]     fill_q;
	logic [gtbr_pkg::GEN_BITS-1:0] wanted_q;
	logic                  wanted_valid_q;
	logic [TW-1:0]         stale_q;
	logic [TW-1:0]         short_q;
	logic [LW-1:0]         written_q;
	logic [FILL_W-1:0]     copies_q;
	logic                  seek_q;
	logic [gtbr_pkg::SEEK_W-1:0] seekf_q;

	// Slot evaluation stage
	gtbr_pkg::slot_t       ent_s1;
	logic                  tag_ok_s1;
	logic signed [DW-1:0]  diff_s1;

	// RAM port
	logic                  ram_we;
	logic [PTR_W-1:0]      ram_waddr;
	gtbr_pkg::slot_t       ram_wdata;
	logic [SLOT_BITS-1:0]  ram_rdata;
	gtbr_pkg::slot_t       rd_slot;

	// Datapath terms
	logic                  new_seek;
	logic                  p_full;
	logic                  p_stale;
	logic                  p_store;
	logic [FILL_W-1:0]     p_fill;
	logic                  walk_go;
	logic signed [FW:0]    diff_wide;
	logic signed [DW-1:0]  diff_sat;
	logic signed [CW-1:0]  d_c;
	logic signed [CW-1:0]  w_c;
	logic signed [CW-1:0]  dl_c;
	logic signed [CW-1:0]  du_c;
	logic signed [CW-1:0]  off_c;
	logic                  drop;
	logic                  stop;
	logic [LW-1:0]         off;
	logic [LW-1:0]         rem_n;
	logic [LW-1:0]         rem_s;
	logic [LW-1:0]         cnt;
	logic [LW-1:0]         new_used;
	logic                  slot_done;
	logic                  emit_copy;
	logic                  underrun;
	logic [TW-1:0]         stale_inc;
	logic [TW-1:0]         short_next;
	logic [PTR_W-1:0]      rp_next;
	logic [PTR_W-1:0]      wp_next;
	logic [PTR_W+gtbr_pkg::SLOT_W-1:0]       slot_wide;
	logic [PTR_W+gtbr_pkg::SLOT_W-1:0]       wslot_wide;
	logic [FILL_W+gtbr_pkg::FILL_OUT_W-1:0]  fill_wide;
	logic [FILL_W+gtbr_pkg::FILL_OUT_W-1:0]  pfill_wide;

	gtbr_ram #(
		.WIDTH(SLOT_BITS),
		.DEPTH(RING_BLOCKS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rp_q),
		.rdata(ram_rdata)
	);

	assign rd_slot = gtbr_pkg::slot_t'(ram_rdata);

	// Push classification: ring full wins over a tag mismatch
	assign new_seek = !wanted_valid_q || (wanted_q != cmd_item.gen);
	assign p_full   = (fill_q == RING_N);
	assign p_stale  = !wanted_valid_q || (item_q.gen != wanted_q);
	assign p_store  = !p_full && !p_stale && (item_q.frames != '0);
	assign p_fill   = p_store ? fill_q + 1'b1 : fill_q;

	// Keep walking while frames are missing and a slot is available
	assign walk_go = (written_q < item_q.frames) && (fill_q != '0) && (copies_q < RING_N);

	// Distance of the slot's first frame from the wanted frame, clamped
	always_comb begin
		diff_wide = $signed({rd_slot.first[FW-1], rd_slot.first})
			- $signed({item_q.frame[FW-1], item_q.frame});
		if (diff_wide > CAP_HI) begin
			diff_sat = DW'(CAP_HI);
		end else if (diff_wide < CAP_LO) begin
			diff_sat = DW'(CAP_LO);
		end else begin
			diff_sat = diff_wide[DW-1:0];
		end
	end

	// Decide what to do with the evaluated head slot
	always_comb begin
		d_c   = CW'(diff_s1);
		w_c   = $signed(CW'(written_q));
		dl_c  = d_c + $signed(CW'(ent_s1.length));
		du_c  = d_c + $signed(CW'(ent_s1.used));
		off_c = w_c - d_c;
		drop  = !tag_ok_s1 || (dl_c <= w_c);
		stop  = (du_c > w_c);
		off   = off_c[LW-1:0];
		rem_n = item_q.frames - written_q;
		rem_s = ent_s1.length - off;
		cnt   = (rem_n > rem_s) ? rem_s : rem_n;
		new_used  = off + cnt;
		slot_done = (new_used == ent_s1.length);
	end

	assign emit_copy  = (state_q == gtbr_pkg::BK_DECIDE) && !drop && !stop;
	assign underrun   = (written_q != item_q.frames);
	assign stale_inc  = (stale_q != '1) ? stale_q + 1'b1 : stale_q;
	assign short_next = (underrun && (short_q != '1)) ? short_q + 1'b1 : short_q;
	assign rp_next    = (rp_q == PTR_W'(RING_BLOCKS - 1)) ? '0 : rp_q + 1'b1;
	assign wp_next    = (wp_q == PTR_W'(RING_BLOCKS - 1)) ? '0 : wp_q + 1'b1;
	assign slot_wide  = {{gtbr_pkg::SLOT_W{1'b0}}, rp_q};
	assign wslot_wide = {{gtbr_pkg::SLOT_W{1'b0}}, wp_q};
	assign fill_wide  = {{gtbr_pkg::FILL_OUT_W{1'b0}}, fill_q};
	assign pfill_wide = {{gtbr_pkg::FILL_OUT_W{1'b0}}, p_fill};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gtbr_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd_item.command == gtbr_pkg::CMD_PUSH)
						? gtbr_pkg::BK_PUSH : gtbr_pkg::BK_ISSUE;
				end
			end
			gtbr_pkg::BK_PUSH: begin
				if (!res_full) begin
					state_d = gtbr_pkg::BK_IDLE;
				end
			end
			gtbr_pkg::BK_ISSUE: begin
				state_d = walk_go ? gtbr_pkg::BK_EVAL : gtbr_pkg::BK_STATUS;
			end
			gtbr_pkg::BK_EVAL: begin
				state_d = gtbr_pkg::BK_DECIDE;
			end
			gtbr_pkg::BK_DECIDE: begin
				if (drop) begin
					state_d = gtbr_pkg::BK_ISSUE;
				end else if (stop) begin
					state_d = gtbr_pkg::BK_STATUS;
				end else if (!res_full) begin
					state_d = gtbr_pkg::BK_ISSUE;
				end
			end
			gtbr_pkg::BK_STATUS: begin
				if (!res_full) begin
					state_d = gtbr_pkg::BK_IDLE;
				end
			end
			default: state_d = gtbr_pkg::BK_IDLE;
		endcase
	end

	// Outputs: command pop, slot writes and result items
	always_comb begin
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = rp_q;
		ram_wdata = ent_s1;
		res_push  = 1'b0;
		res_item  = '0;
		unique case (state_q)
			gtbr_pkg::BK_IDLE: begin
				cmd_pop = cmd_valid;
			end
			gtbr_pkg::BK_PUSH: begin
				ram_we           = p_store && !res_full;
				ram_waddr        = wp_q;
				ram_wdata.first  = item_q.frame;
				ram_wdata.length = item_q.frames;
				ram_wdata.used   = '0;
				ram_wdata.tag    = item_q.gen;
				res_push         = !res_full;
				res_item.kind    = gtbr_pkg::KIND_PUSH;
				res_item.slot_index  = p_store ? wslot_wide[gtbr_pkg::SLOT_W-1:0] : '0;
				res_item.copy_frames = p_store ? item_q.frames : '0;
				res_item.status  = p_full ? gtbr_pkg::ST_FULL
					: (p_stale ? gtbr_pkg::ST_STALE : gtbr_pkg::ST_OK);
				res_item.ring_fill = pfill_wide[gtbr_pkg::FILL_OUT_W-1:0];
				res_item.stale_dropped_total = stale_q;
				res_item.underrun_total      = short_q;
				res_item.last    = 1'b1;
			end
			gtbr_pkg::BK_DECIDE: begin
				ram_we         = emit_copy && !res_full;
				ram_wdata.used = new_used;
				res_push       = emit_copy && !res_full;
				res_item.kind  = gtbr_pkg::KIND_COPY;
				res_item.slot_index    = slot_wide[gtbr_pkg::SLOT_W-1:0];
				res_item.source_offset = off[gtbr_pkg::OFS_W-1:0];
				res_item.dest_offset   = written_q[gtbr_pkg::OFS_W-1:0];
				res_item.copy_frames   = cnt;
				res_item.status        = gtbr_pkg::ST_OK;
			end
			gtbr_pkg::BK_STATUS: begin
				res_push       = !res_full;
				res_item.kind  = gtbr_pkg::KIND_RENDER;
				res_item.copy_frames  = written_q;
				res_item.status       = underrun ? gtbr_pkg::ST_UNDERRUN : gtbr_pkg::ST_OK;
				res_item.seek_request = seek_q;
				res_item.seek_frame   = seekf_q;
				res_item.ring_fill    = fill_wide[gtbr_pkg::FILL_OUT_W-1:0];
				res_item.stale_dropped_total = stale_q;
				res_item.underrun_total      = short_next;
				res_item.last  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Latch the command and evaluate the head slot
	always_ff @(posedge clk) begin
		if (state_q == gtbr_pkg::BK_IDLE && cmd_valid) begin
			item_q <= cmd_item;
		end
		if (state_q == gtbr_pkg::BK_EVAL) begin
			ent_s1    <= rd_slot;
			tag_ok_s1 <= (rd_slot.tag == item_q.gen);
			diff_s1   <= diff_sat;
		end
	end

	// Ring pointers, counters and per-render bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= gtbr_pkg::BK_IDLE;
			rp_q           <= '0;
			wp_q           <= '0;
			fill_q         <= '0;
			wanted_q       <= '0;
			wanted_valid_q <= 1'b0;
			stale_q        <= '0;
			short_q        <= '0;
			written_q      <= '0;
			copies_q       <= '0;
			seek_q         <= 1'b0;
			seekf_q        <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				gtbr_pkg::BK_IDLE: begin
					if (cmd_valid && cmd_item.command == gtbr_pkg::CMD_RENDER) begin
						written_q <= '0;
						copies_q  <= '0;
						seek_q    <= new_seek;
						seekf_q   <= (new_seek && !cmd_item.frame[FW-1])
							? cmd_item.frame[gtbr_pkg::SEEK_W-1:0] : '0;
						wanted_q       <= cmd_item.gen;
						wanted_valid_q <= 1'b1;
					end
				end
				gtbr_pkg::BK_PUSH: begin
					if (!res_full && p_store) begin
						wp_q   <= wp_next;
						fill_q <= p_fill;
					end
				end
				gtbr_pkg::BK_DECIDE: begin
					if (drop) begin
						rp_q    <= rp_next;
						fill_q  <= fill_q - 1'b1;
						stale_q <= stale_inc;
					end else if (!stop && !res_full) begin
						written_q <= written_q + cnt;
						copies_q  <= copies_q + 1'b1;
						if (slot_done) begin
							rp_q   <= rp_next;
							fill_q <= fill_q - 1'b1;
						end
					end
				end
				gtbr_pkg::BK_STATUS: begin
					if (!res_full) begin
						short_q <= short_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hdl/generation_tagged_block_ring_reader.sv -----
// Top level of the generation-tagged block ring reader: front end, executing back end
// and result queue. Depends on gtbr_pkg, gtbr_front, gtbr_back and gtbr_fifo.
//
// Push a command with push while full is low; pop results with pop while empty is low.
// A push command yields one push-status item. A render yields one copy item per usable
// ring slot and then a render-status item; the status item always carries last = 1.
// Commands wait in a two-entry queue and results in a two-entry queue, so either side
// may stall without blocking the other. The back end handles one command at a time;
// a render takes each ring slot it inspects through a slot memory read, a frame-distance
// compare and a decision. Every inspected slot but the last leaves the ring, so a render
// inspects at most RING_BLOCKS slots. A full result queue stalls the back end. The slot
// descriptors live in a RAM of RING_BLOCKS entries whose contents are undefined until
// pushed.
module generation_tagged_block_ring_reader #(
	parameter int RING_BLOCKS = gtbr_pkg::RING_BLOCKS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             command,
	input  logic [gtbr_pkg::FRAME_BITS-1:0]  start_frame,
	input  logic [gtbr_pkg::LEN_W-1:0]       frame_count,
	input  logic [gtbr_pkg::GEN_BITS-1:0]    generation,
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       kind,
	output logic [gtbr_pkg::SLOT_W-1:0]      slot_index,
	output logic [gtbr_pkg::OFS_W-1:0]       source_offset,
	output logic [gtbr_pkg::OFS_W-1:0]       dest_offset,
	output logic [gtbr_pkg::LEN_W-1:0]       copy_frames,
	output logic [1:0]                       status,
	output logic                             seek_request,
	output logic [gtbr_pkg::SEEK_W-1:0]      seek_frame,
	output logic [gtbr_pkg::FILL_OUT_W-1:0]  ring_fill,
	output logic [gtbr_pkg::TOTAL_W-1:0]     stale_dropped_total,
	output logic [gtbr_pkg::TOTAL_W-1:0]     underrun_total,
	output logic                             last
);

	localparam int RES_W = $bits(gtbr_pkg::result_t);

	logic                cmd_valid;
	gtbr_pkg::cmd_item_t cmd_item;
	logic                cmd_pop;
	logic                res_full;
	logic                res_push;
	gtbr_pkg::result_t   res_item;
	logic [RES_W-1:0]    res_head;
	gtbr_pkg::result_t   head;

	gtbr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.start_frame(start_frame),
		.frame_count(frame_count),
		.generation (generation),
		.cmd_valid  (cmd_valid),
		.cmd_item   (cmd_item),
		.cmd_pop    (cmd_pop)
	);

	gtbr_back #(
		.RING_BLOCKS(RING_BLOCKS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_item (cmd_item),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_item (res_item)
	);

	gtbr_fifo #(
		.WIDTH(RES_W),
		.DEPTH(gtbr_pkg::QUEUE_DEPTH)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res_item),
		.full  (res_full),
		.rd    (pop),
		.rdata (res_head),
		.empty (empty)
	);

	// Spread the oldest result onto the ports
	assign head                = gtbr_pkg::result_t'(res_head);
	assign kind                = head.kind;
	assign slot_index          = head.slot_index;
	assign source_offset       = head.source_offset;
	assign dest_offset         = head.dest_offset;
	assign copy_frames         = head.copy_frames;
	assign status              = head.status;
	assign seek_request        = head.seek_request;
	assign seek_frame          = head.seek_frame;
	assign ring_fill           = head.ring_fill;
	assign stale_dropped_total = head.stale_dropped_total;
	assign underrun_total      = head.underrun_total;
	assign last                = head.last;

endmodule
